### hdl/arqgb_pkg.sv
// shared types and constants for the go-back arq sender
`timescale 1ns / 1ps
package arqgb_pkg;

    localparam int SEQ_W                 = 16;
    localparam int RETRY_W               = 5;
    localparam int CMD_W                 = 2;
    localparam int ACT_W                 = 2;
    localparam int HISTORY_DEPTH_DEFAULT = 16;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 5'd5;
    localparam logic [RETRY_W-1:0] RETRY_MAX         = 5'd31;
    localparam logic [SEQ_W-1:0]   SEQ_RESET         = 16'd1;

    // event kinds on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_NACK    = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

    // result kinds on the output channel
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE = 2'd0,
        ACT_TX   = 2'd1,
        ACT_DONE = 2'd2,
        ACT_FAIL = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SEARCH = 1'b1
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic [SEQ_W-1:0] key;
    } tok_t;

endpackage

### hdl/arq_sender_with_go_back_history.sv
// Stop-and-wait arq sender with nack go-back over a row of history cells.
// Send, ack, timeout and non-searching responses register their result, which
// shows in the cycle after the input transfer; a nack go-back walks the cell row
// one cell per cycle and registers its result once a slot matches or none does.
// Throughput: one event per cycle; a search or an untaken result holds off the input.
// Reset (aresetn low, synchronous) clears valid bits, pointers, counters; expected 1, limit 5.
`timescale 1ns / 1ps
module arq_sender_with_go_back_history
    import arqgb_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT,
    parameter int SLOT_W        = $clog2(HISTORY_DEPTH),
    parameter int OUT_DW        = ((SEQ_W + 2 * SLOT_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input events
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SEQ_W-1:0]   s_tdata,   // [15:0] seq_in
    input  logic [CMD_W-1:0]   s_tuser,   // [1:0] command
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_DW-1:0]  m_tdata,   // tx_seq, payload_slot, record_slot, zero fill
    output logic [ACT_W-1:0]   m_tuser,   // [1:0] action
    // retry limit register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RETRY_W-1:0] cfg_data
);

    state_t             state_reg, state_next;
    logic               busy_reg, busy_next;
    logic [SEQ_W-1:0]   exp_reg, exp_next;
    logic [RETRY_W-1:0] retries_reg, retries_next;
    logic [SLOT_W-1:0]  wp_reg, wp_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SEQ_W-1:0]   key_reg, key_next;
    logic               launch_reg, launch_next;
    logic [RETRY_W-1:0] limit_reg;

    logic               m_valid_reg;
    action_t            act_reg;
    logic [SEQ_W-1:0]   oseq_reg;
    logic [SLOT_W-1:0]  opay_reg, orec_reg;

    logic               accept;
    cmd_t               cmd;
    logic [SEQ_W-1:0]   seq_in;

    logic               out_load;
    action_t            out_act;
    logic [SEQ_W-1:0]   out_seq;
    logic [SLOT_W-1:0]  out_pay, out_rec;

    logic               wr_en;
    logic [SEQ_W-1:0]   wr_seq;
    logic [SLOT_W-1:0]  wp_inc;

    logic               retry_go;
    logic [SLOT_W-1:0]  retry_pay;
    logic [RETRY_W-1:0] r_base, r_cnt;
    logic [SEQ_W-1:0]   seq_eff;
    logic               tx_go;
    logic [SLOT_W-1:0]  tx_pay;

    tok_t                     tok_vec [0:HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hit_vec;
    logic                     hit_any;
    logic                     miss;
    logic [SLOT_W-1:0]        hit_slot;

    assign accept    = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign seq_in    = s_tdata;
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign wp_inc = (wp_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // row of history cells, token enters at slot 0
    assign tok_vec[0].active = launch_reg;
    assign tok_vec[0].key    = key_reg;

    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        arqgb_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_en && (wp_reg == SLOT_W'(i))),
            .wr_seq  (wr_seq),
            .tok_in  (tok_vec[i]),
            .tok_out (tok_vec[i+1]),
            .hit     (hit_vec[i])
        );
    end

    assign hit_any = |hit_vec;
    assign miss    = tok_vec[HISTORY_DEPTH].active;

    // encode the matching slot
    always_comb begin
        hit_slot = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (hit_vec[i]) begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (launch_next) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit_any || miss) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // event decision, retry counting and transmission record
    always_comb begin
        busy_next    = busy_reg;
        exp_next     = exp_reg;
        retries_next = retries_reg;
        wp_next      = wp_reg;
        cur_next     = cur_reg;
        key_next     = key_reg;
        launch_next  = 1'b0;
        out_load     = 1'b0;
        out_act      = ACT_NONE;
        out_seq      = '0;
        out_pay      = '0;
        out_rec      = '0;
        wr_en        = 1'b0;
        wr_seq       = exp_reg;
        retry_go     = 1'b0;
        retry_pay    = cur_reg;
        r_base       = retries_reg;
        seq_eff      = exp_reg;
        tx_go        = 1'b0;
        tx_pay       = wp_reg;

        if (accept) begin
            out_load = 1'b1;
            case (cmd)
                CMD_SEND: begin
                    if (busy_reg) begin
                        out_act = ACT_NONE;
                    end else if (limit_reg == '0) begin
                        out_act = ACT_FAIL;
                        out_seq = exp_reg;
                    end else begin
                        busy_next    = 1'b1;
                        retries_next = '0;
                        tx_go        = 1'b1;
                        tx_pay       = wp_reg;
                    end
                end
                default: begin
                    if (!busy_reg) begin
                        out_act = ACT_NONE;
                    end else if (cmd == CMD_ACK && seq_in == exp_reg) begin
                        busy_next = 1'b0;
                        out_act   = ACT_DONE;
                        out_seq   = exp_reg;
                        exp_next  = exp_reg + 1'b1;
                    end else if (cmd == CMD_NACK && seq_in < exp_reg) begin
                        // walk the history for the lowest matching slot
                        out_load    = 1'b0;
                        launch_next = 1'b1;
                        key_next    = seq_in;
                    end else begin
                        retry_go = 1'b1;
                    end
                end
            endcase
        end else if (state_reg == ST_SEARCH) begin
            if (hit_any) begin
                out_load  = 1'b1;
                retry_go  = 1'b1;
                r_base    = '0;
                retry_pay = hit_slot;
                seq_eff   = key_reg;
                exp_next  = key_reg;
            end else if (miss) begin
                out_load = 1'b1;
                retry_go = 1'b1;
            end
        end

        // one more retry, saturating
        r_cnt = (r_base != RETRY_MAX) ? r_base + 1'b1 : r_base;
        if (retry_go) begin
            retries_next = r_cnt;
            if (r_cnt < limit_reg) begin
                tx_go  = 1'b1;
                tx_pay = retry_pay;
            end else begin
                busy_next = 1'b0;
                out_act   = ACT_FAIL;
                out_seq   = seq_eff;
            end
        end

        // record the transmission at the write pointer
        if (tx_go) begin
            wr_en    = 1'b1;
            wr_seq   = seq_eff;
            wp_next  = wp_inc;
            cur_next = wp_reg;
            out_act  = ACT_TX;
            out_seq  = seq_eff;
            out_pay  = tx_pay;
            out_rec  = wp_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            exp_reg     <= SEQ_RESET;
            retries_reg <= '0;
            wp_reg      <= '0;
            cur_reg     <= '0;
            launch_reg  <= 1'b0;
            limit_reg   <= RETRY_LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            exp_reg     <= exp_next;
            retries_reg <= retries_next;
            wp_reg      <= wp_next;
            cur_reg     <= cur_next;
            launch_reg  <= launch_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (out_load) begin
            act_reg  <= out_act;
            oseq_reg <= out_seq;
            opay_reg <= out_pay;
            orec_reg <= out_rec;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = act_reg;
    assign m_tdata  = OUT_DW'({orec_reg, opay_reg, oseq_reg});

    // a search token matches in at most one cell
    a_hit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("more than one history cell matched");

    // a result never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    // a go-back search only runs while a packet is in flight
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> busy_reg)
        else $error("search while idle");

    // the write pointer stays inside the ring
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= SLOT_W'(HISTORY_DEPTH - 1))
        else $error("write pointer out of range");

endmodule

### hdl/arqgb_cell.sv
// one history slot: stored sequence number, valid bit and a search token stage
`timescale 1ns / 1ps
module arqgb_cell
    import arqgb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [SEQ_W-1:0] wr_seq,
    input  tok_t             tok_in,
    output tok_t             tok_out,
    output logic             hit
);

    logic             valid_reg;
    logic             valid_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic             tok_active_reg;
    logic [SEQ_W-1:0] tok_key_reg;
    tok_t             tok_next;

    // compare the passing token against this slot
    assign hit = tok_in.active && valid_reg && (seq_reg == tok_in.key);

    always_comb begin
        valid_next = valid_reg;
        seq_next   = seq_reg;
        if (wr_en) begin
            valid_next = 1'b1;
            seq_next   = wr_seq;
        end
        // a token that found its match stops here
        tok_next.active = tok_in.active && !hit;
        tok_next.key    = tok_in.key;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_active_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            tok_active_reg <= tok_next.active;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        seq_reg     <= seq_next;
        tok_key_reg <= tok_next.key;
    end

    assign tok_out.active = tok_active_reg;
    assign tok_out.key    = tok_key_reg;

endmodule
